### hw/rtl/stt_pkg.sv
// Shared constants, payload structs and a saturating-move helper for the step-toward-target block.
// Used by the channel interfaces, the square-root and divider cells and the core.
package stt_pkg;

  localparam int unsigned CoordBits  = 24;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned SpeedBits  = 20;
  localparam int unsigned StopBits   = 12;
  localparam int unsigned SpanBits   = CoordBits + 1;
  localparam int unsigned DeltaBits  = CoordBits + 1;
  localparam int unsigned RadBits    = 2 * SpanBits;
  localparam int unsigned SqrtCells  = SpanBits;
  localparam int unsigned RemBits    = SpanBits + 4;
  localparam int unsigned StepBits   = SpeedBits + 1;
  localparam int unsigned QuotBits   = StepBits;
  localparam int unsigned ProdBits   = StepBits + DeltaBits;
  localparam int unsigned DivCells   = QuotBits;
  localparam int unsigned RemainBits = SpanBits + 2;
  localparam int unsigned SumBits    = CoordBits + 2;

  typedef struct packed {
    logic signed [CoordBits-1:0] sx;
    logic signed [CoordBits-1:0] sy;
    logic                        negx;
    logic                        negy;
    logic [DeltaBits-1:0]        ax;
    logic [DeltaBits-1:0]        ay;
    logic [SpeedBits-1:0]        speed;
    logic [StopBits-1:0]         stop;
  } side_t;

  typedef struct packed {
    logic [RadBits-1:0]  rad;
    logic [RemBits-1:0]  rem;
    logic [SpanBits-1:0] root;
    side_t               side;
  } sqrt_t;

  typedef struct packed {
    logic [SpanBits-1:0] span;
    logic [StepBits-1:0] mag;
    logic                neg;
    side_t               side;
  } step_t;

  typedef struct packed {
    logic [SpanBits-1:0]         dvs;
    logic [SpanBits-1:0]         remx;
    logic [SpanBits-1:0]         remy;
    logic [QuotBits-1:0]         lowx;
    logic [QuotBits-1:0]         lowy;
    logic [QuotBits-1:0]         qx;
    logic [QuotBits-1:0]         qy;
    logic signed [CoordBits-1:0] sx;
    logic signed [CoordBits-1:0] sy;
    logic                        negx;
    logic                        negy;
  } div_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] next_x;
    logic signed [CoordBits-1:0] next_y;
    logic [SpanBits-1:0]         span;
    logic                        coincident;
  } res_t;

  function automatic logic signed [CoordBits-1:0] sat_move(
    input logic signed [CoordBits-1:0] s,
    input logic [QuotBits-1:0]         mag,
    input logic                        neg
  );
    logic signed [SumBits-1:0] ext_s;
    logic signed [SumBits-1:0] ext_m;
    logic signed [SumBits-1:0] sum;
    logic signed [SumBits-1:0] hi;
    logic signed [SumBits-1:0] lo;
    ext_s = SumBits'(s);
    ext_m = $signed(SumBits'(mag));
    hi    = $signed({{(SumBits-CoordBits+1){1'b0}}, {(CoordBits-1){1'b1}}});
    lo    = $signed({{(SumBits-CoordBits+1){1'b1}}, {(CoordBits-1){1'b0}}});
    sum   = neg ? (ext_s - ext_m) : (ext_s + ext_m);
    if (sum > hi) begin
      sum = hi;
    end else if (sum < lo) begin
      sum = lo;
    end
    return sum[CoordBits-1:0];
  endfunction

endpackage

### hw/rtl/stt_in_if.sv
// Request channel of the step-toward-target block: valid, ready and one request.
// Depends on stt_pkg for field widths.
interface stt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [stt_pkg::CoordBits-1:0] start_x;
  logic signed [stt_pkg::CoordBits-1:0] start_y;
  logic signed [stt_pkg::CoordBits-1:0] target_x;
  logic signed [stt_pkg::CoordBits-1:0] target_y;
  logic [stt_pkg::SpeedBits-1:0]        move_speed;
  logic [stt_pkg::StopBits-1:0]         stop_distance;

  modport source(output valid, start_x, start_y, target_x, target_y, move_speed,
                 stop_distance, input ready);
  modport sink(input valid, start_x, start_y, target_x, target_y, move_speed,
               stop_distance, output ready);
endinterface

### hw/rtl/stt_out_if.sv
// Result channel of the step-toward-target block: valid, ready and one result.
// Depends on stt_pkg for field widths.
interface stt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [stt_pkg::CoordBits-1:0] next_x;
  logic signed [stt_pkg::CoordBits-1:0] next_y;
  logic [stt_pkg::SpanBits-1:0]         span;
  logic                                coincident;

  modport source(output valid, next_x, next_y, span, coincident, input ready);
  modport sink(input valid, next_x, next_y, span, coincident, output ready);
endinterface

### hw/rtl/step_toward_target_core.sv
// Pipeline stages: delta, square, 25 root cells, step, multiply, 21 divider cells, output.
// Throughput one request per cycle; the whole pipe advances whenever the output
// register is empty or being taken, so a stall on the result side holds every stage.
// Reset (rst_ni low, asynchronous) clears all valid bits; no other state.
// Depends on stt_pkg, stt_in_if, stt_out_if, stt_sqrt_cell and stt_div_cell.
module step_toward_target_core (
  input  logic clk_i,
  input  logic rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  logic en;
  logic out_valid_q;
  stt_pkg::res_t res_d, res_q;

  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // delta stage
  logic signed [stt_pkg::DeltaBits-1:0] dx, dy;
  stt_pkg::side_t s1_d, s1_q;
  logic           s1_valid_q;

  always_comb begin
    dx = stt_pkg::DeltaBits'(in_i.target_x) - stt_pkg::DeltaBits'(in_i.start_x);
    dy = stt_pkg::DeltaBits'(in_i.target_y) - stt_pkg::DeltaBits'(in_i.start_y);
    s1_d.sx    = in_i.start_x;
    s1_d.sy    = in_i.start_y;
    s1_d.negx  = dx[stt_pkg::DeltaBits-1];
    s1_d.negy  = dy[stt_pkg::DeltaBits-1];
    s1_d.ax    = dx[stt_pkg::DeltaBits-1] ? -dx : dx;
    s1_d.ay    = dy[stt_pkg::DeltaBits-1] ? -dy : dy;
    s1_d.speed = in_i.move_speed;
    s1_d.stop  = in_i.stop_distance;
  end

  // square stage
  stt_pkg::sqrt_t sq_data [stt_pkg::SqrtCells+1];
  logic           sq_valid [stt_pkg::SqrtCells+1];
  logic [stt_pkg::RadBits-1:0] sqx, sqy;
  stt_pkg::sqrt_t s2_d, s2_q;
  logic           s2_valid_q;

  always_comb begin
    sqx       = s1_q.ax * s1_q.ax;
    sqy       = s1_q.ay * s1_q.ay;
    s2_d.rad  = sqx + sqy;
    s2_d.rem  = '0;
    s2_d.root = '0;
    s2_d.side = s1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign sq_data[0]  = s2_q;
  assign sq_valid[0] = s2_valid_q;

  for (genvar i = 0; i < stt_pkg::SqrtCells; i++) begin : g_sqrt
    stt_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // step stage
  stt_pkg::sqrt_t                        sq_end;
  logic signed [stt_pkg::RemainBits-1:0] remain, speed_s, step;
  stt_pkg::step_t                        s3_d, s3_q;
  logic                                  s3_valid_q;

  always_comb begin
    sq_end  = sq_data[stt_pkg::SqrtCells];
    speed_s = $signed(stt_pkg::RemainBits'(sq_end.side.speed));
    remain  = $signed(stt_pkg::RemainBits'(sq_end.root))
            - $signed(stt_pkg::RemainBits'({sq_end.side.stop, {stt_pkg::FracBits{1'b0}}}));
    step    = (remain > speed_s) ? speed_s : remain;
    s3_d.span = sq_end.root;
    s3_d.neg  = step[stt_pkg::RemainBits-1];
    s3_d.mag  = step[stt_pkg::RemainBits-1] ? stt_pkg::StepBits'(-step)
                                            : stt_pkg::StepBits'(step);
    s3_d.side = sq_end.side;
  end

  // multiply stage
  logic [stt_pkg::ProdBits-1:0] px, py;
  stt_pkg::div_t                s4_d, s4_q;
  logic                         s4_valid_q;

  always_comb begin
    px = s3_q.mag * s3_q.side.ax;
    py = s3_q.mag * s3_q.side.ay;
    s4_d.dvs  = s3_q.span;
    s4_d.remx = px[stt_pkg::ProdBits-1:stt_pkg::QuotBits];
    s4_d.remy = py[stt_pkg::ProdBits-1:stt_pkg::QuotBits];
    s4_d.lowx = px[stt_pkg::QuotBits-1:0];
    s4_d.lowy = py[stt_pkg::QuotBits-1:0];
    s4_d.qx   = '0;
    s4_d.qy   = '0;
    s4_d.sx   = s3_q.side.sx;
    s4_d.sy   = s3_q.side.sy;
    s4_d.negx = s3_q.neg ^ s3_q.side.negx;
    s4_d.negy = s3_q.neg ^ s3_q.side.negy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= sq_valid[stt_pkg::SqrtCells];
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  stt_pkg::div_t dv_data [stt_pkg::DivCells+1];
  logic          dv_valid [stt_pkg::DivCells+1];

  assign dv_data[0]  = s4_q;
  assign dv_valid[0] = s4_valid_q;

  for (genvar j = 0; j < stt_pkg::DivCells; j++) begin : g_div
    stt_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[j]),
      .data_i  (dv_data[j]),
      .valid_o (dv_valid[j+1]),
      .data_o  (dv_data[j+1])
    );
  end

  // output stage
  stt_pkg::div_t dv_end;

  always_comb begin
    dv_end = dv_data[stt_pkg::DivCells];
    res_d.span       = dv_end.dvs;
    res_d.coincident = (dv_end.dvs == '0);
    if (res_d.coincident) begin
      res_d.next_x = dv_end.sx;
      res_d.next_y = dv_end.sy;
    end else begin
      res_d.next_x = stt_pkg::sat_move(dv_end.sx, dv_end.qx, dv_end.negx);
      res_d.next_y = stt_pkg::sat_move(dv_end.sy, dv_end.qy, dv_end.negy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[stt_pkg::DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.next_x     = res_q.next_x;
  assign out_o.next_y     = res_q.next_y;
  assign out_o.span       = res_q.span;
  assign out_o.coincident = res_q.coincident;

endmodule

### hw/rtl/stt_sqrt_cell.sv
// One cell of the square-root chain: retires one root bit per cell.
// Depends on stt_pkg.
module stt_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  stt_pkg::sqrt_t data_i,
  output logic           valid_o,
  output stt_pkg::sqrt_t data_o
);

  logic [stt_pkg::RemBits+1:0] rem_n;
  logic [stt_pkg::RemBits+1:0] trial;
  logic [stt_pkg::RemBits+1:0] diff;
  stt_pkg::sqrt_t              data_d, data_q;
  logic                        valid_q;

  always_comb begin
    rem_n  = {data_i.rem, data_i.rad[stt_pkg::RadBits-1 -: 2]};
    trial  = {{(stt_pkg::RemBits-stt_pkg::SpanBits){1'b0}}, data_i.root, 2'b01};
    diff   = rem_n - trial;
    data_d = data_i;
    data_d.rad = {data_i.rad[stt_pkg::RadBits-3:0], 2'b00};
    if (rem_n >= trial) begin
      data_d.rem  = diff[stt_pkg::RemBits-1:0];
      data_d.root = {data_i.root[stt_pkg::SpanBits-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_n[stt_pkg::RemBits-1:0];
      data_d.root = {data_i.root[stt_pkg::SpanBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/stt_div_cell.sv
// One cell of the divider chain: one quotient bit per cell for both x and y.
// Depends on stt_pkg.
module stt_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  stt_pkg::div_t data_i,
  output logic          valid_o,
  output stt_pkg::div_t data_o
);

  logic [stt_pkg::SpanBits:0] rx, ry, dv, dfx, dfy;
  logic                       gex, gey;
  stt_pkg::div_t              data_d, data_q;
  logic                       valid_q;

  always_comb begin
    dv  = {1'b0, data_i.dvs};
    rx  = {data_i.remx, data_i.lowx[stt_pkg::QuotBits-1]};
    ry  = {data_i.remy, data_i.lowy[stt_pkg::QuotBits-1]};
    gex = rx >= dv;
    gey = ry >= dv;
    dfx = rx - dv;
    dfy = ry - dv;
    data_d      = data_i;
    data_d.remx = gex ? dfx[stt_pkg::SpanBits-1:0] : rx[stt_pkg::SpanBits-1:0];
    data_d.remy = gey ? dfy[stt_pkg::SpanBits-1:0] : ry[stt_pkg::SpanBits-1:0];
    data_d.lowx = {data_i.lowx[stt_pkg::QuotBits-2:0], 1'b0};
    data_d.lowy = {data_i.lowy[stt_pkg::QuotBits-2:0], 1'b0};
    data_d.qx   = {data_i.qx[stt_pkg::QuotBits-2:0], gex};
    data_d.qy   = {data_i.qy[stt_pkg::QuotBits-2:0], gey};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### bench/step_toward_target_core_test.sv
// Self-checking bench for step_toward_target_core: random and directed move requests,
// results predicted in the bench and compared field by field in order.
// Depends on stt_pkg, stt_in_if, stt_out_if and the core RTL.
module step_toward_target_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [stt_pkg::CoordBits-1:0] sx;
    logic signed [stt_pkg::CoordBits-1:0] sy;
    logic signed [stt_pkg::CoordBits-1:0] tx;
    logic signed [stt_pkg::CoordBits-1:0] ty;
    logic [stt_pkg::SpeedBits-1:0]        speed;
    logic [stt_pkg::StopBits-1:0]         stop;
  } move_req_t;

  localparam int Latency = 51;
  localparam longint CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  stt_in_if  req_if ();
  stt_out_if res_if ();

  step_toward_target_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  move_req_t      pending_q[$];
  stt_pkg::res_t  expected_q[$];
  int        send_idle_pct = 14;
  int        recv_idle_pct = 45;
  int        mismatches = 0;
  int        moves_sent;
  int        results_seen = 0;
  int        coincident_seen = 0;
  int        saturated_seen = 0;
  longint    cycles;
  bit        hold_send = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((n >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [stt_pkg::CoordBits-1:0] move_axis(
    longint s, longint t, longint stride, longint span_len
  );
    longint delta;
    longint mag;
    longint nxt;
    longint hi;
    longint lo;
    logic [127:0] prod;
    delta = t - s;
    hi = (64'sd1 <<< (stt_pkg::CoordBits - 1)) - 1;
    lo = -hi - 1;
    prod = 128'((stride < 0) ? -stride : stride) * 128'((delta < 0) ? -delta : delta);
    mag = longint'(prod / 128'(span_len));
    nxt = (((stride < 0) != (delta < 0)) ? s - mag : s + mag);
    if (nxt > hi) nxt = hi;
    if (nxt < lo) nxt = lo;
    return nxt[stt_pkg::CoordBits-1:0];
  endfunction

  function automatic stt_pkg::res_t predict_move(move_req_t r);
    stt_pkg::res_t o;
    longint sx, sy, tx, ty, dx, dy, span_len, remain, stride;
    sx = r.sx; sy = r.sy; tx = r.tx; ty = r.ty;
    dx = tx - sx;
    dy = ty - sy;
    span_len = longint'(isqrt(128'(dx * dx) + 128'(dy * dy)));
    o.span = span_len[stt_pkg::SpanBits-1:0];
    o.coincident = (span_len == 0);
    o.next_x = r.sx;
    o.next_y = r.sy;
    if (span_len != 0) begin
      remain = span_len - (longint'(r.stop) << stt_pkg::FracBits);
      stride = (remain > longint'(r.speed)) ? longint'(r.speed) : remain;
      o.next_x = move_axis(sx, tx, stride, span_len);
      o.next_y = move_axis(sy, ty, stride, span_len);
    end
    return o;
  endfunction

  function automatic logic signed [stt_pkg::CoordBits-1:0] rand_coord(int mode);
    case (mode)
      0: return stt_pkg::CoordBits'($urandom);
      1: return stt_pkg::CoordBits'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom_range(0, 1) ? {1'b0, {(stt_pkg::CoordBits-1){1'b1}}}
                                            : {1'b1, {(stt_pkg::CoordBits-1){1'b0}}};
    endcase
  endfunction

  task automatic add_move(move_req_t r);
    pending_q.push_back(r);
  endtask

  task automatic add_random_move();
    move_req_t r;
    int m;
    m = $urandom_range(0, 9);
    r.sx = rand_coord(m < 5 ? 0 : (m < 9 ? 1 : 2));
    r.sy = rand_coord(m < 5 ? 0 : (m < 9 ? 1 : 2));
    r.tx = ($urandom_range(0, 7) == 0) ? r.sx
         : (m >= 5 && m < 9)
           ? r.sx + stt_pkg::CoordBits'($signed($urandom_range(0, 8000)) - 4000)
           : rand_coord(m < 5 ? 0 : 2);
    r.ty = ($urandom_range(0, 7) == 0) ? r.sy
         : (m >= 5 && m < 9)
           ? r.sy + stt_pkg::CoordBits'($signed($urandom_range(0, 8000)) - 4000)
           : rand_coord(m < 5 ? 0 : 2);
    r.speed = ($urandom_range(0, 3) == 0) ? stt_pkg::SpeedBits'($urandom_range(0, 2000))
                                          : stt_pkg::SpeedBits'($urandom);
    r.stop = ($urandom_range(0, 2) == 0) ? stt_pkg::StopBits'($urandom_range(0, 20))
                                         : stt_pkg::StopBits'($urandom);
    add_move(r);
  endtask

  initial begin
    localparam logic signed [stt_pkg::CoordBits-1:0] Max = {1'b0, {(stt_pkg::CoordBits-1){1'b1}}};
    localparam logic signed [stt_pkg::CoordBits-1:0] Min = {1'b1, {(stt_pkg::CoordBits-1){1'b0}}};
    localparam logic [stt_pkg::SpeedBits-1:0] SpeedMax = '1;
    localparam logic [stt_pkg::StopBits-1:0]  StopMax = '1;
    add_move('{0, 0, 0, 0, 0, 0});
    add_move('{Max, Min, Max, Min, SpeedMax, StopMax});
    add_move('{Min, Min, Max, Max, SpeedMax, 0});
    add_move('{Max, Max, Min, Min, SpeedMax, 0});
    add_move('{Min, Max, Max, Min, SpeedMax, StopMax});
    add_move('{Max, 0, Min, 0, 0, StopMax});
    add_move('{Min, 0, Max, 0, 1, StopMax});
    add_move('{0, 0, 3, 4, 2, 0});
    add_move('{0, 0, 1, 1, SpeedMax, 0});
    add_move('{0, 0, 1000, 0, 100, 1});
    add_move('{0, 0, 100, 0, 500, 1});
    add_move('{Max - 10, 0, Max, 0, 100, StopMax});
    add_move('{Min + 10, 5, Min, 5, 100, StopMax});
    add_move('{-7, 3, -7, 3, SpeedMax, StopMax});
    add_move('{100, -200, -300, 400, 700, 2});
    add_move('{0, 0, -256, 0, SpeedMax, 1});
    add_move('{0, 0, 0, Min, SpeedMax, StopMax});
    add_move('{0, 0, 7, 7, 3, 0});
    for (int i = 0; i < 400; i++) add_random_move();
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.start_x <= '0;
      req_if.start_y <= '0;
      req_if.target_x <= '0;
      req_if.target_y <= '0;
      req_if.move_speed <= '0;
      req_if.stop_distance <= '0;
      moves_sent <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        moves_sent <= moves_sent + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_q.size() != 0 && !hold_send
            && $urandom_range(0, 99) >= send_idle_pct) begin
          move_req_t r;
          r = pending_q.pop_front();
          expected_q.push_back(predict_move(r));
          req_if.valid <= 1'b1;
          req_if.start_x <= r.sx;
          req_if.start_y <= r.sy;
          req_if.target_x <= r.tx;
          req_if.target_y <= r.ty;
          req_if.move_speed <= r.speed;
          req_if.stop_distance <= r.stop;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %0d", results_seen);
      end else begin
        stt_pkg::res_t e;
        e = expected_q.pop_front();
        if (e.coincident) coincident_seen <= coincident_seen + 1;
        if (e.next_x == {1'b0, {(stt_pkg::CoordBits-1){1'b1}}}
            || e.next_x == {1'b1, {(stt_pkg::CoordBits-1){1'b0}}})
          saturated_seen <= saturated_seen + 1;
        if (res_if.next_x !== e.next_x || res_if.next_y !== e.next_y
            || res_if.span !== e.span || res_if.coincident !== e.coincident) begin
          if (mismatches < 10)
            $display("result %0d: expected x=%0d y=%0d span=%0d co=%0b, got x=%0d y=%0d span=%0d co=%0b",
                     results_seen, e.next_x, e.next_y, e.span, e.coincident,
                     res_if.next_x, res_if.next_y, res_if.span, res_if.coincident);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("step_toward_target_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (pending_q.size() < 300);
    hold_send = 1'b1;
    wait (pending_q.size() < 300 && expected_q.size() == 0);
    @(posedge clk_i);
    hold_send = 1'b0;
    wait (pending_q.size() < 200);
    send_idle_pct = 45;
    recv_idle_pct = 14;
    wait (pending_q.size() < 100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (2 * Latency) @(posedge clk_i);
    $display("covered %0d requests, %0d results: %0d coincident, %0d saturated on x",
             moves_sent, results_seen, coincident_seen, saturated_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("step_toward_target_core: match");
    end else begin
      $display("step_toward_target_core: mismatch");
    end
    $finish;
  end
endmodule
